[src/lfa_pkg.sv]
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared widths, fixed-point constants, sequencer types and the quarter-wave
// sin^2 table of the Levy fitness accumulator.
// ----------------------------------------------------------------------------
package lfa_pkg;

    localparam int FRAC_BITS            = 16;
    localparam int SINE_TABLE_ADDR_BITS = 10;

    localparam int COORD_W = 32;
    localparam int FIT_W   = 48;
    localparam int PHASE_W = 32;
    localparam int SIN2_W  = 17;
    localparam int GAIN_W  = 20;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int WIDE_W  = PROD_W + GAIN_W;

    // (w-1)^2 carries 2*FRAC_BITS+4 fraction bits, the gain 16
    localparam int SCALE_SHIFT = FRAC_BITS + 20;
    // pi*w is (z+3)/8 turns, 2*pi*w is (z+3)/4 turns
    localparam int HALF_SHIFT  = PHASE_W - FRAC_BITS - 3;
    localparam int FULL_SHIFT  = PHASE_W - FRAC_BITS - 2;

    localparam int QUARTER = 1 << (SINE_TABLE_ADDR_BITS - 2);
    localparam int QIDX_W  = SINE_TABLE_ADDR_BITS - 1;

    localparam logic [PHASE_W-1:0] INV_TWO_PI_TURNS = 32'd683565276;
    localparam logic [FIT_W-1:0]   SUM_MAX          = '1;
    localparam logic [SIN2_W-1:0]  Q16_ONE          = 17'h10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_HI,
        ST_LO,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic busy;
        logic load;
        logic sq;
        logic hi;
        logic lo;
        logic acc;
    } t_ctrl;

    typedef logic [SIN2_W-1:0] t_sin2_table [QUARTER+1];

    // sin^2 in Q16 for each quarter-wave position, polynomial sine capped at one
    function automatic t_sin2_table build_sin2_table();
        t_sin2_table     tbl;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned inner;
        longint unsigned p;
        int              m;
        for (m = 0; m <= QUARTER; m++) begin
            x     = 64'(m) << (18 - SINE_TABLE_ADDR_BITS);
            x2    = (x * x) >> 16;
            inner = 64'd42334 - ((x2 * 64'd4926) >> 16);
            inner = 64'd102944 - ((x2 * inner) >> 16);
            p     = (x * inner) >> 16;
            if (p > 64'd65536) begin
                p = 64'd65536;
            end
            tbl[m] = SIN2_W'((p * p) >> 16);
        end
        return tbl;
    endfunction

    localparam t_sin2_table SIN2_TABLE = build_sin2_table();

endpackage

[src/lfa_sine.sv]
// ----------------------------------------------------------------------------
// lfa_sine
// sin^2 of a turn phase: truncate to the table address, fold into the quarter
// wave and look up the Q16 value.
// ----------------------------------------------------------------------------
module lfa_sine
    import lfa_pkg::*;
(
    input  logic [PHASE_W-1:0] i_phase,
    output logic [SIN2_W-1:0]  o_sin2
);

    logic [SINE_TABLE_ADDR_BITS-1:0] idx;
    logic [QIDX_W-1:0]               pos;
    logic [QIDX_W-1:0]               mirror;

    assign idx    = i_phase[PHASE_W-1 -: SINE_TABLE_ADDR_BITS];
    assign pos    = {1'b0, idx[SINE_TABLE_ADDR_BITS-3:0]};
    assign mirror = QIDX_W'(QUARTER) - pos;

    // mirror in the second and fourth quarters
    always_comb begin
        o_sin2 = idx[SINE_TABLE_ADDR_BITS-2] ? SIN2_TABLE[mirror] : SIN2_TABLE[pos];
    end

endmodule

[src/lfa_mul.sv]
// ----------------------------------------------------------------------------
// lfa_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module lfa_mul
    import lfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

[src/lfa_seq.sv]
// ----------------------------------------------------------------------------
// lfa_seq
// Step sequencer: accept, square, high and low partial products, accumulate.
// ----------------------------------------------------------------------------
module lfa_seq
    import lfa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_emit_blocked,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.load = i_valid;
                if (i_valid) begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_ctrl.busy = 1'b1;
                o_ctrl.sq   = 1'b1;
                n_state     = ST_HI;
            end
            ST_HI: begin
                o_ctrl.busy = 1'b1;
                o_ctrl.hi   = 1'b1;
                n_state     = ST_LO;
            end
            ST_LO: begin
                o_ctrl.busy = 1'b1;
                o_ctrl.lo   = 1'b1;
                n_state     = ST_ACC;
            end
            ST_ACC: begin
                o_ctrl.busy = 1'b1;
                // hold while the previous fitness still waits
                o_ctrl.acc  = !i_emit_blocked;
                if (!i_emit_blocked) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[src/levy_fitness_accumulator_unit.sv]
// ----------------------------------------------------------------------------
// levy_fitness_accumulator_unit
// Levy benchmark fitness of one particle, accumulated coordinate by coordinate.
// ----------------------------------------------------------------------------
// A coordinate passes through the accept step, then square, high
// partial product, low partial product and accumulate. The steps are set by
// the single 32x32 multiplier, used three times per coordinate to form
// (w-1)^2 and scale it by its sin^2 gain. The fitness beat appears in the
// output register the cycle after the last coordinate's accumulate; that
// accumulate waits while an earlier fitness beat is still stalled, and
// coordinates that do not end a particle never wait on the output side.
module levy_fitness_accumulator_unit
    import lfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [COORD_W-1:0] i_coord,
    input  logic               i_is_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [FIT_W-1:0]   o_fitness
);

    t_ctrl ctrl;

    logic [COORD_W-1:0] r_coord;
    logic               r_is_last;
    logic [MUL_W-1:0]   r_mag;
    logic [GAIN_W-1:0]  r_g;
    logic [MUL_W-1:0]   r_sq_lo;
    logic [PROD_W-1:0]  r_hi_prod;
    logic [FIT_W-1:0]   r_sum;
    logic               r_first;
    logic               r_out_valid;
    logic [FIT_W-1:0]   r_fitness;

    logic [FIT_W-1:0]   n_sum;
    logic               n_first;
    logic               n_out_valid;
    logic [FIT_W-1:0]   n_fitness;

    logic [COORD_W:0]   diff;
    logic [COORD_W:0]   diff_neg;
    logic [MUL_W-1:0]   mag;
    logic [PHASE_W-1:0] v;
    logic [PHASE_W-1:0] half_phase;
    logic [PHASE_W-1:0] phase_b;
    logic [SIN2_W-1:0]  s2a;
    logic [SIN2_W-1:0]  s2b;
    logic [SIN2_W+FRAC_BITS-1:0] term1_w;
    logic [FIT_W-1:0]   term1;
    logic [GAIN_W-1:0]  gain;
    logic [WIDE_W-1:0]  wide;
    logic [WIDE_W-1:0]  scaled;
    logic [FIT_W-1:0]   term2;
    logic [FIT_W-1:0]   acc_sum;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod;
    logic               emit_blocked;

    function automatic logic [FIT_W-1:0] add_sat(logic [FIT_W-1:0] a, logic [FIT_W-1:0] b);
        logic [FIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FIT_W] ? SUM_MAX : s[FIT_W-1:0];
    endfunction

    assign emit_blocked = r_is_last && r_out_valid && i_stall;

    lfa_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_emit_blocked (emit_blocked),
        .o_ctrl         (ctrl)
    );

    // |z - 1|, exact
    assign diff     = {i_coord[COORD_W-1], i_coord} - (COORD_W+1)'(1 << FRAC_BITS);
    assign diff_neg = ~diff + 1'b1;
    assign mag      = diff[COORD_W] ? diff_neg[MUL_W-1:0] : diff[MUL_W-1:0];

    // phases in turns
    assign v          = r_coord + PHASE_W'(3 << FRAC_BITS);
    assign half_phase = v << HALF_SHIFT;
    assign phase_b    = r_is_last ? (v << FULL_SHIFT) : (half_phase + INV_TWO_PI_TURNS);

    lfa_sine u_sine_a (
        .i_phase (half_phase),
        .o_sin2  (s2a)
    );

    lfa_sine u_sine_b (
        .i_phase (phase_b),
        .o_sin2  (s2b)
    );

    assign term1_w = {s2a, FRAC_BITS'(0)} >> 16;
    assign term1   = FIT_W'(term1_w);
    assign gain    = r_is_last ? (GAIN_W'(Q16_ONE) + GAIN_W'(s2b))
                               : (GAIN_W'(Q16_ONE) + (GAIN_W'(s2b) << 3) + (GAIN_W'(s2b) << 1));

    // shared multiplier operands per step
    always_comb begin
        mul_a = r_sq_lo;
        mul_b = MUL_W'(r_g);
        if (ctrl.sq) begin
            mul_a = r_mag;
            mul_b = r_mag;
        end else if (ctrl.hi) begin
            mul_a = prod[PROD_W-1:MUL_W];
        end
    end

    lfa_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (ctrl.sq || ctrl.hi || ctrl.lo),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign wide   = (WIDE_W'(r_hi_prod) << MUL_W) + WIDE_W'(prod);
    assign scaled = wide >> SCALE_SHIFT;
    assign term2  = (|scaled[WIDE_W-1:FIT_W]) ? SUM_MAX : scaled[FIT_W-1:0];
    assign acc_sum = add_sat(r_sum, term2);

    always_comb begin
        n_sum       = r_sum;
        n_first     = r_first;
        n_out_valid = r_out_valid && i_stall;
        n_fitness   = r_fitness;
        if (ctrl.sq && r_first) begin
            n_sum = add_sat(r_sum, term1);
        end
        if (ctrl.acc) begin
            if (r_is_last) begin
                // emit and rearm
                n_out_valid = 1'b1;
                n_fitness   = acc_sum;
                n_sum       = '0;
                n_first     = 1'b1;
            end else begin
                n_sum   = acc_sum;
                n_first = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fitness <= n_fitness;
        if (ctrl.load) begin
            r_coord   <= i_coord;
            r_is_last <= i_is_last;
            r_mag     <= mag;
        end
        if (ctrl.sq) begin
            r_g <= gain;
        end
        if (ctrl.hi) begin
            r_sq_lo <= prod[MUL_W-1:0];
        end
        if (ctrl.lo) begin
            r_hi_prod <= prod;
        end
    end

    assign o_stall   = ctrl.busy;
    assign o_valid   = r_out_valid;
    assign o_fitness = r_fitness;

    a_load_then_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.load |=> ctrl.sq)
        else $error("square step did not follow an accepted coordinate");

    a_rearm_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.acc && r_is_last) |=> (r_sum == '0) && r_first && r_out_valid)
        else $error("accumulator did not rearm after emitting a fitness");

    a_no_emit_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.acc && r_is_last) |-> !(r_out_valid && i_stall))
        else $error("fitness emitted over a stalled pending beat");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctrl.load, ctrl.sq, ctrl.hi, ctrl.lo, ctrl.acc}))
        else $error("more than one sequencer step active");

endmodule
